// ----- rtl/core/plt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_pkg
// Widths, codes and the per-cell control bundle of the positional list table.
// ----------------------------------------------------------------------------
package plt_pkg;

    localparam int DEPTH   = 32;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CMD_W   = 2;
    localparam int POS_W   = 6;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 3;
    localparam int CNT_W   = 6;
    localparam int CMP_W   = 7;
    localparam int IN_W    = 40;
    localparam int OUT_RAW = STAT_W + VAL_W + POS_W + CNT_W;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_TRAVERSE = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_DELETE,
        OP_ROTATE
    } plt_op_t;

    typedef struct packed {
        plt_op_t           op;
        logic [POS_W-1:0]  pos_idx;
        logic [CNT_W-1:0]  count;
        logic [VAL_W-1:0]  value;
    } plt_ctl_t;

endpackage

// ----- rtl/core/plt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_cell
// One slot of the list: holds an entry, shifts to or from its neighbours,
// compares against the search key and offers its entry for removal.
// ----------------------------------------------------------------------------
module plt_cell (
    input  logic                        clk,
    input  logic [plt_pkg::IDX_W-1:0]   idx,
    input  plt_pkg::plt_ctl_t           ctl,
    input  logic [plt_pkg::VAL_W-1:0]   prev_entry,
    input  logic [plt_pkg::VAL_W-1:0]   next_entry,
    input  logic [plt_pkg::VAL_W-1:0]   wrap_entry,
    output logic [plt_pkg::VAL_W-1:0]   entry,
    output logic                        match,
    output logic [plt_pkg::VAL_W-1:0]   pick
);
    import plt_pkg::*;

    logic [VAL_W-1:0] entry_reg;
    logic [VAL_W-1:0] entry_next;
    logic             match_reg;
    logic             match_next;
    logic [CMP_W-1:0] i_c;
    logic [CMP_W-1:0] i1_c;
    logic [CMP_W-1:0] p_c;
    logic [CMP_W-1:0] c_c;

    assign i_c  = CMP_W'(idx);
    assign i1_c = CMP_W'(idx) + CMP_W'(1);
    assign p_c  = CMP_W'(ctl.pos_idx);
    assign c_c  = CMP_W'(ctl.count);

    always_comb
    begin
        entry_next = entry_reg;
        unique case (ctl.op)
            OP_INSERT:
            begin
                if (i_c == p_c)
                    entry_next = ctl.value;
                else if (i_c > p_c && i_c <= c_c)
                    entry_next = prev_entry;
            end
            OP_DELETE:
            begin
                if (i_c >= p_c && i1_c < c_c)
                    entry_next = next_entry;
            end
            OP_ROTATE:
            begin
                if (i1_c < c_c)
                    entry_next = next_entry;
                else if (i1_c == c_c)
                    entry_next = wrap_entry;
            end
            default:
                entry_next = entry_reg;
        endcase
    end

    assign match_next = (entry_reg == ctl.value) && (i_c < c_c);

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        match_reg <= match_next;
    end

    assign entry = entry_reg;
    assign match = match_reg;
    assign pick  = (i_c == p_c) ? entry_reg : '0;

endmodule

// ----- rtl/core/positional_list_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_table
// Packed list of up to DEPTH unsigned entries with insert, delete, search and
// traverse commands, built as a chain of entry cells.
//
// Input beats carry cmd, position and value; output beats carry status, data,
// found_position and entry_count, with tlast on the final beat of a command.
// One command is in work at a time. Insert, delete and the error cases give
// their beat in the output register in the cycle after acceptance. Search
// registers every cell's compare, then encodes the first match into the
// output register. Traverse sends one entry per cycle while the output is
// not stalled, rotating the chain by one cell each beat, and leaves the list
// in its original order.
// A stalled output holds its beat and freezes the chain; no input is taken
// until the output register can be refilled.
// Reset clears the count and the control state; entries are valid only
// below the count.
// ----------------------------------------------------------------------------
module positional_list_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // cmd[1:0], position[7:2], value[39:8]
    input  logic [plt_pkg::IN_W-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // status[2:0], data[34:3], found_position[40:35], entry_count[46:41]
    output logic [plt_pkg::OUT_W-1:0]   m_tdata,
    output logic                        m_tlast
);
    import plt_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_TRAV   = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  trav_reg, trav_next;
    logic              ovalid_reg, ovalid_next;
    logic [STAT_W-1:0] ostat_reg, ostat_next;
    logic [VAL_W-1:0]  odata_reg, odata_next;
    logic [POS_W-1:0]  ofound_reg, ofound_next;
    logic              olast_reg, olast_next;

    logic [CMD_W-1:0]  in_cmd;
    logic [POS_W-1:0]  in_pos;
    logic [VAL_W-1:0]  in_value;
    logic              out_free;
    logic              accept;
    plt_ctl_t          ctl;

    logic [VAL_W-1:0]  entry_w [DEPTH];
    logic [VAL_W-1:0]  pick_w  [DEPTH];
    logic [DEPTH-1:0]  match_w;
    logic [VAL_W-1:0]  pick_or;
    logic              found_any;
    logic [IDX_W-1:0]  found_idx;
    logic [CMP_W-1:0]  pos_c;
    logic [CMP_W-1:0]  cnt_c;

    assign in_cmd   = s_tdata[CMD_W-1:0];
    assign in_pos   = s_tdata[CMD_W +: POS_W];
    assign in_value = s_tdata[CMD_W+POS_W +: VAL_W];
    assign pos_c    = CMP_W'(in_pos);
    assign cnt_c    = CMP_W'(count_reg);

    assign out_free = !ovalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic [VAL_W-1:0] prev_w;
            logic [VAL_W-1:0] next_w;
            if (g == 0)
            begin : g_first
                assign prev_w = '0;
            end
            else
            begin : g_mid
                assign prev_w = entry_w[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_end
                assign next_w = '0;
            end
            else
            begin : g_inner
                assign next_w = entry_w[g+1];
            end
            plt_cell u_cell (
                .clk        (clk),
                .idx        (IDX_W'(g)),
                .ctl        (ctl),
                .prev_entry (prev_w),
                .next_entry (next_w),
                .wrap_entry (entry_w[0]),
                .entry      (entry_w[g]),
                .match      (match_w[g]),
                .pick       (pick_w[g])
            );
        end
    endgenerate

    always_comb
    begin
        pick_or = '0;
        for (int i = 0; i < DEPTH; i++)
            pick_or = pick_or | pick_w[i];
    end

    always_comb
    begin
        found_any = 1'b0;
        found_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (match_w[i])
            begin
                found_any = 1'b1;
                found_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        trav_next   = trav_reg;
        ovalid_next = ovalid_reg && !m_tready;
        ostat_next  = ostat_reg;
        odata_next  = odata_reg;
        ofound_next = ofound_reg;
        olast_next  = olast_reg;
        ctl.op      = OP_HOLD;
        ctl.pos_idx = in_pos - POS_W'(1);
        ctl.count   = count_reg;
        ctl.value   = in_value;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ovalid_next = 1'b1;
                    ostat_next  = ST_OK;
                    odata_next  = '0;
                    ofound_next = '0;
                    olast_next  = 1'b1;
                    unique case (in_cmd)
                        CMD_INSERT:
                        begin
                            if (cnt_c >= CMP_W'(DEPTH))
                                ostat_next = ST_FULL;
                            else if (in_pos == '0 || pos_c > cnt_c + CMP_W'(1))
                                ostat_next = ST_BADPOS;
                            else
                            begin
                                ctl.op     = OP_INSERT;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (count_reg == '0)
                                ostat_next = ST_EMPTY;
                            else if (in_pos == '0 || pos_c > cnt_c)
                                ostat_next = ST_BADPOS;
                            else
                            begin
                                ctl.op     = OP_DELETE;
                                odata_next = pick_or;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        CMD_SEARCH:
                        begin
                            ovalid_next = ovalid_reg && !m_tready;
                            state_next  = S_SEARCH;
                        end
                        CMD_TRAVERSE:
                        begin
                            if (count_reg == '0)
                                ostat_next = ST_EMPTY;
                            else
                            begin
                                ovalid_next = ovalid_reg && !m_tready;
                                trav_next   = '0;
                                state_next  = S_TRAV;
                            end
                        end
                        default:
                            ostat_next = ST_OK;
                    endcase
                end
            end
            S_SEARCH:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = '0;
                    olast_next  = 1'b1;
                    ostat_next  = found_any ? ST_OK : ST_NOTFOUND;
                    ofound_next = found_any ? POS_W'(found_idx) + POS_W'(1) : '0;
                    state_next  = S_IDLE;
                end
            end
            S_TRAV:
            begin
                if (out_free)
                begin
                    ctl.op      = OP_ROTATE;
                    ovalid_next = 1'b1;
                    ostat_next  = ST_OK;
                    odata_next  = entry_w[0];
                    ofound_next = '0;
                    olast_next  = (trav_reg + CNT_W'(1) == count_reg);
                    trav_next   = trav_reg + CNT_W'(1);
                    if (trav_reg + CNT_W'(1) == count_reg)
                        state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            trav_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            trav_reg   <= trav_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ostat_reg  <= ostat_next;
        odata_reg  <= odata_next;
        ofound_reg <= ofound_next;
        olast_reg  <= olast_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = OUT_W'({count_reg, ofound_reg, odata_reg, ostat_reg});

endmodule
